/* src/lpg_pkg.sv */
// Shared types and constants of the line pixel generator.
package lpg_pkg;

	localparam int COORD_W     = 7;
	localparam int COLOR_W     = 16;
	localparam int IN_COORD_W  = 8;
	localparam int MAX_RESULTS = 64;
	localparam int CNT_W       = $clog2(MAX_RESULTS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int ERR_W       = COORD_W + 2;

	// One classified line, ordered along its major axis.
	typedef struct packed {
		logic [COORD_W-1:0] maj_start;
		logic [COORD_W-1:0] maj_end;
		logic [COORD_W-1:0] min_start;
		logic [COORD_W-1:0] dmaj;
		logic [COORD_W-1:0] dmin;
		logic               steep;
		logic               up;
		logic [COLOR_W-1:0] color;
	} lpg_cmd_t;

endpackage

/* src/lpg_front.sv */
// Command front end: range check, axis swap and end point ordering.
module lpg_front #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic [lpg_pkg::IN_COORD_W-1:0] x_start,
	input  logic [lpg_pkg::IN_COORD_W-1:0] y_start,
	input  logic [lpg_pkg::IN_COORD_W-1:0] x_end,
	input  logic [lpg_pkg::IN_COORD_W-1:0] y_end,
	input  logic [lpg_pkg::COLOR_W-1:0]    pen_color,
	input  logic                           take,
	output logic                           push,
	output lpg_pkg::lpg_cmd_t              cmd
);
	import lpg_pkg::*;

	logic               on_screen;
	logic [COORD_W-1:0] xa, ya, xb, yb;
	logic [COORD_W-1:0] dx, dy;
	logic               steep;
	logic [COORD_W-1:0] a_maj, a_min, b_maj, b_min;
	logic [COORD_W-1:0] s_maj, s_min, e_maj, e_min;

	always_comb begin
		on_screen = (x_start < IN_COORD_W'(SCREEN_WIDTH)) && (x_end < IN_COORD_W'(SCREEN_WIDTH)) &&
			(y_start < IN_COORD_W'(SCREEN_HEIGHT)) && (y_end < IN_COORD_W'(SCREEN_HEIGHT));
		xa = x_start[COORD_W-1:0];
		ya = y_start[COORD_W-1:0];
		xb = x_end[COORD_W-1:0];
		yb = y_end[COORD_W-1:0];
		dx = (xa > xb) ? (xa - xb) : (xb - xa);
		dy = (ya > yb) ? (ya - yb) : (yb - ya);
		// vertical and horizontal lines fall out as dmin of zero
		steep = dy > dx;
		a_maj = steep ? ya : xa;
		a_min = steep ? xa : ya;
		b_maj = steep ? yb : xb;
		b_min = steep ? xb : yb;
		if (a_maj > b_maj) begin
			s_maj = b_maj;
			s_min = b_min;
			e_maj = a_maj;
			e_min = a_min;
		end else begin
			s_maj = a_maj;
			s_min = a_min;
			e_maj = b_maj;
			e_min = b_min;
		end
		cmd.maj_start = s_maj;
		cmd.maj_end   = e_maj;
		cmd.min_start = s_min;
		cmd.dmaj      = e_maj - s_maj;
		cmd.dmin      = (s_min > e_min) ? (s_min - e_min) : (e_min - s_min);
		cmd.steep     = steep;
		cmd.up        = s_min < e_min;
		cmd.color     = pen_color;
		// drop off-screen lines here
		push = take && on_screen;
	end

endmodule

/* src/lpg_queue.sv */
// Short queue of classified lines between front end and engine.
module lpg_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lpg_pkg::lpg_cmd_t wr_cmd,
	input  logic              pop,
	output lpg_pkg::lpg_cmd_t rd_cmd,
	output logic              not_empty,
	output logic              full
);
	import lpg_pkg::*;

	lpg_cmd_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign not_empty = count_q != '0;
	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/lpg_engine.sv */
// Bresenham stepping engine: one pixel per cycle from a classified line.
module lpg_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_ready,
	input  lpg_pkg::lpg_cmd_t           cmd,
	output logic                        pop,
	output logic                        valid,
	output logic [lpg_pkg::COORD_W-1:0] pixel_x,
	output logic [lpg_pkg::COORD_W-1:0] pixel_y,
	output logic [lpg_pkg::COLOR_W-1:0] pixel_color,
	output logic                        last_pixel
);
	import lpg_pkg::*;

	logic                     active_q;
	logic [COORD_W-1:0]       maj_q, maj_end_q, min_q, dmaj_q, dmin_q;
	logic                     steep_q, up_q;
	logic [COLOR_W-1:0]       color_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  err_sub;
	logic                     last;

	always_comb begin
		last    = (maj_q == maj_end_q) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
		err_sub = err_q - $signed({2'b00, dmin_q});
		pop     = cmd_ready && (!active_q || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid    <= 1'b0;
		end else begin
			valid <= active_q;
			if (pop) begin
				active_q <= 1'b1;
			end else if (active_q && last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			pixel_x     <= steep_q ? min_q : maj_q;
			pixel_y     <= steep_q ? maj_q : min_q;
			pixel_color <= color_q;
			last_pixel  <= last;
		end
		if (pop) begin
			maj_q     <= cmd.maj_start;
			maj_end_q <= cmd.maj_end;
			min_q     <= cmd.min_start;
			dmaj_q    <= cmd.dmaj;
			dmin_q    <= cmd.dmin;
			steep_q   <= cmd.steep;
			up_q      <= cmd.up;
			color_q   <= cmd.color;
			cnt_q     <= '0;
			err_q     <= $signed({2'b00, 1'b0, cmd.dmaj[COORD_W-1:1]});
		end else if (active_q) begin
			maj_q <= maj_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
			// step the minor axis when the error goes negative
			if (err_sub < 0) begin
				min_q <= up_q ? (min_q + 1'b1) : (min_q - 1'b1);
				err_q <= err_sub + $signed({2'b00, dmaj_q});
			end else begin
				err_q <= err_sub;
			end
		end
	end

endmodule

/* src/line_pixel_generator_top.sv */
// Top level of the line pixel generator.
//
//   channel   direction  handshake            word
//   command   in         start / busy         x_start y_start x_end y_end pen_color
//   pixel     out        valid (strobe)       pixel_x pixel_y pixel_color last_pixel
//
// A line of N pixels (N = major axis span + 1, at most 64) leaves the
// stepping engine at one pixel per cycle; the engine loop sets the rate.
// A command taken into an idle block goes through the queue, the engine and the
// output registers; queued lines follow each other with no gap.
// Reset empties the queue and idles the engine. busy is high while the queue is
// full; off-screen commands are taken and dropped. The receiver cannot stall.
module line_pixel_generator_top #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [lpg_pkg::IN_COORD_W-1:0] x_start,
	input  logic [lpg_pkg::IN_COORD_W-1:0] y_start,
	input  logic [lpg_pkg::IN_COORD_W-1:0] x_end,
	input  logic [lpg_pkg::IN_COORD_W-1:0] y_end,
	input  logic [lpg_pkg::COLOR_W-1:0]    pen_color,
	output logic                           valid,
	output logic [lpg_pkg::COORD_W-1:0]    pixel_x,
	output logic [lpg_pkg::COORD_W-1:0]    pixel_y,
	output logic [lpg_pkg::COLOR_W-1:0]    pixel_color,
	output logic                           last_pixel
);
	import lpg_pkg::*;

	lpg_cmd_t front_cmd, queue_cmd;
	logic     push, pop, not_empty, full;

	assign busy = full;

	lpg_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.pen_color(pen_color),
		.take     (start && !full),
		.push     (push),
		.cmd      (front_cmd)
	);

	lpg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (front_cmd),
		.pop      (pop),
		.rd_cmd   (queue_cmd),
		.not_empty(not_empty),
		.full     (full)
	);

	lpg_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_ready  (not_empty),
		.cmd        (queue_cmd),
		.pop        (pop),
		.valid      (valid),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.last_pixel (last_pixel)
	);

endmodule

/* src/lpg_checker.sv */
// Port-level checks of the line pixel generator, bound to the top level.
module lpg_checker #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        valid,
	input logic [lpg_pkg::COORD_W-1:0] pixel_x,
	input logic [lpg_pkg::COORD_W-1:0] pixel_y,
	input logic [lpg_pkg::COLOR_W-1:0] pixel_color,
	input logic                        last_pixel
);
	import lpg_pkg::*;

	// every pixel lands on screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (pixel_x < COORD_W'(SCREEN_WIDTH - 1) || pixel_x == COORD_W'(SCREEN_WIDTH - 1))
			&& (pixel_y < COORD_W'(SCREEN_HEIGHT - 1) || pixel_y == COORD_W'(SCREEN_HEIGHT - 1)))
		else $error("pixel off screen");

	// pixels of one line come out back to back
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_pixel |=> valid)
		else $error("gap inside a line");

	// color holds over a line
	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_pixel |=> pixel_color == $past(pixel_color))
		else $error("color changed inside a line");

	// successive pixels of a line are neighbors
	a_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_pixel |=>
			(pixel_x == $past(pixel_x) || pixel_x == COORD_W'($past(pixel_x) + 1'b1)
				|| pixel_x == COORD_W'($past(pixel_x) - 1'b1))
			&& (pixel_y == $past(pixel_y) || pixel_y == COORD_W'($past(pixel_y) + 1'b1)
				|| pixel_y == COORD_W'($past(pixel_y) - 1'b1)))
		else $error("pixels not adjacent");

endmodule

bind line_pixel_generator_top lpg_checker #(
	.SCREEN_WIDTH (SCREEN_WIDTH),
	.SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_lpg_checker (.*);
